[rtl/core/ptrp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ptrp_pkg;

	// Character codes used by the reply grammar
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_T     = 8'h74;

	// Reply kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_FAILURE = 2'd0;
	localparam kind_t KIND_SUCCESS = 2'd1;
	localparam kind_t KIND_PAN     = 2'd2;
	localparam kind_t KIND_TILT    = 2'd3;

	localparam int ACC_W = 31;
	localparam logic [34:0] POS_LIMIT = 35'd2147483647;

	// Request queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One classified request byte
	typedef struct packed {
		logic [7:0] data;
		logic       blank;
		logic       digit;
		logic       minus;
		logic       eol;
	} token_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == 8'd9) || (b == 8'd10) || (b == 8'd11) || (b == 8'd12) ||
			(b == 8'd13) || (b == 8'd32) || (b == 8'h85) || (b == 8'hA0);
	endfunction

endpackage

`default_nettype wire

[rtl/core/pan_tilt_reply_parser.sv]
// Pan-tilt reply parser. Takes one reply byte per request on the input channel
// and, at each carriage return, returns at most one result: failure ('!' first),
// success (only '*' and blanks), or a pan or tilt position for lines opening with
// "pp" or "tp", with all digits gathered into one signed value (0 when the
// magnitude passes 2147483647). Blank and unrecognised lines return nothing.
// Rate: one byte per clock while the queue is not full. A byte lands in a
// four-entry request queue on the cycle it is accepted; the back end consumes
// one byte per cycle unless a carriage return waits on a held result, and
// out_valid is registered when it pops a carriage return. The input stalls
// only when the queue is full, as a held result blocks the next carriage return.
`timescale 1ns / 1ps
`default_nettype none

module pan_tilt_reply_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              reply_kind,
	output logic signed [31:0]      position
);
	import ptrp_pkg::*;

	token_t push_token;
	token_t head_token;
	qstat_t q_stat;
	logic   push;
	logic   pop;

	// Front: classify each byte and push it into the queue
	ptrp_front u_front (
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.q_stat   (q_stat),
		.in_stall (in_stall),
		.push     (push),
		.token    (push_token)
	);

	// Queue: decouple classification from line tracking
	ptrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_token (push_token),
		.pop        (pop),
		.head_token (head_token),
		.q_stat     (q_stat)
	);

	// Back: advance the line state, judge the line at each carriage return
	ptrp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_token (head_token),
		.q_empty    (q_stat.empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.reply_kind (reply_kind),
		.position   (position)
	);

	// Failure and success never carry a position
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (reply_kind == KIND_FAILURE || reply_kind == KIND_SUCCESS))
		|-> (position == 32'sd0))
		else $error("non-zero position on failure or success");

	// The overflow-to-zero rule keeps the most negative code unreachable
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (position != 32'sh8000_0000))
		else $error("position out of range");

	// Queue occupancy stays within its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QDEPTH))
		else $error("request queue overfilled");

	// An accepted request leaves the queue non-empty on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !q_stat.empty)
		else $error("accepted request lost");

endmodule

`default_nettype wire

[rtl/core/ptrp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ptrp_front (
	input  wire logic            in_valid,
	input  wire logic [7:0]      rx_byte,
	input  wire ptrp_pkg::qstat_t q_stat,
	output logic                 in_stall,
	output logic                 push,
	output ptrp_pkg::token_t     token
);
	import ptrp_pkg::*;

	// Hold the sender off only while the queue is full
	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		token.data  = rx_byte;
		token.blank = is_blank(rx_byte);
		token.digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
		token.minus = (rx_byte == CH_MINUS);
		token.eol   = (rx_byte == CH_CR);
	end

endmodule

`default_nettype wire

[rtl/core/ptrp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ptrp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ptrp_pkg::token_t push_token,
	input  wire logic             pop,
	output ptrp_pkg::token_t      head_token,
	output ptrp_pkg::qstat_t      q_stat
);
	import ptrp_pkg::*;

	token_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.count = count_q;
	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head_token   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/ptrp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ptrp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ptrp_pkg::token_t head_token,
	input  wire logic             q_empty,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output ptrp_pkg::kind_t       reply_kind,
	output logic signed [31:0]    position
);
	import ptrp_pkg::*;

	logic [1:0]       lead_count_q;
	logic [7:0]       first_char_q;
	logic [7:0]       second_char_q;
	logic             later_nonblank_q;
	logic             minus_seen_q;
	logic [ACC_W-1:0] digit_accum_q;
	logic             accum_overflow_q;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [31:0]      pos_q;

	logic             have;
	kind_t            kind_d;
	logic [31:0]      pos_d;
	logic [ACC_W-1:0] mag;
	logic [34:0]      next_acc;

	assign out_valid  = out_valid_q;
	assign reply_kind = kind_q;
	assign position   = pos_q;

	// A line end needs the output register free or draining
	assign pop = !q_empty && (!head_token.eol || !out_valid_q || !out_stall);

	assign next_acc = {1'b0, digit_accum_q, 3'b000} + {3'b000, digit_accum_q, 1'b0}
		+ {31'd0, head_token.data[3:0]};

	always_comb begin
		have   = 1'b0;
		kind_d = KIND_FAILURE;
		pos_d  = '0;
		mag    = accum_overflow_q ? '0 : digit_accum_q;
		if (lead_count_q != 2'd0) begin
			priority if (first_char_q == CH_BANG) begin
				have = 1'b1;
			end else if (first_char_q == CH_STAR && !later_nonblank_q) begin
				have   = 1'b1;
				kind_d = KIND_SUCCESS;
			end else if (lead_count_q == 2'd2 && second_char_q == CH_P &&
				(first_char_q == CH_P || first_char_q == CH_T)) begin
				have   = 1'b1;
				kind_d = (first_char_q == CH_P) ? KIND_PAN : KIND_TILT;
				pos_d  = minus_seen_q ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_token.eol && have) begin
			kind_q <= kind_d;
			pos_q  <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q      <= 1'b0;
			lead_count_q     <= '0;
			first_char_q     <= '0;
			second_char_q    <= '0;
			later_nonblank_q <= 1'b0;
			minus_seen_q     <= 1'b0;
			digit_accum_q    <= '0;
			accum_overflow_q <= 1'b0;
		end else begin
			if (pop && head_token.eol && have) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (pop && head_token.eol) begin
				lead_count_q     <= '0;
				first_char_q     <= '0;
				second_char_q    <= '0;
				later_nonblank_q <= 1'b0;
				minus_seen_q     <= 1'b0;
				digit_accum_q    <= '0;
				accum_overflow_q <= 1'b0;
			end else if (pop) begin
				if (lead_count_q == 2'd0) begin
					if (!head_token.blank) begin
						first_char_q <= head_token.data;
						lead_count_q <= 2'd1;
					end
				end else begin
					if (lead_count_q == 2'd1) begin
						second_char_q <= head_token.data;
						lead_count_q  <= 2'd2;
					end
					if (!head_token.blank) begin
						later_nonblank_q <= 1'b1;
					end
				end
				if (head_token.minus) begin
					minus_seen_q <= 1'b1;
				end
				if (head_token.digit && !accum_overflow_q) begin
					if (next_acc > POS_LIMIT) begin
						accum_overflow_q <= 1'b1;
						digit_accum_q    <= '0;
					end else begin
						digit_accum_q <= next_acc[ACC_W-1:0];
					end
				end
			end
		end
	end

endmodule

`default_nettype wire
